### rtl/core/ivt_pkg.sv
// Shared types and constants for the three-channel interval timer.
package ivt_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] CONTROL_PORT = 2'd3;

   localparam logic [1:0] SEL_READBACK = 2'd3;
   localparam logic [1:0] RW_LATCH     = 2'd0;
   localparam logic [1:0] RW_16BIT     = 2'd3;
   localparam logic [3:0] MODE_RATEGEN = 4'h4;
   localparam logic [3:0] MODE_SQWAVE  = 4'h6;

   localparam logic [15:0] COUNT_MAX       = 16'hffff;
   localparam logic [15:0] DIVISOR_DEFAULT = 16'd11932;

   // Per-channel command for one accepted beat
   typedef struct packed {
      logic       tick;
      logic       latch;
      logic       clr_latch;
      logic       rd;
      logic       wr;
      logic [7:0] wdata;
   } chan_cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
   } rsp_type;

endpackage

### rtl/core/ivt_channel.sv
// One timer channel: reload, phase, write sequencing and count latch.
module ivt_channel (
   input  logic                  clock,
   input  logic                  reset,
   input  ivt_pkg::chan_cmd_type cmd,
   input  logic [15:0]           divisor,
   output logic [7:0]            rd_byte
);
   import ivt_pkg::*;

   logic [15:0] reload_ff, reload_in;
   logic [15:0] phase_ff, phase_in;
   logic [7:0]  pend_ff, pend_in;
   logic        high_next_ff, high_next_in;
   logic [15:0] latched_ff, latched_in;
   logic [1:0]  left_ff, left_in;
   logic [15:0] wr_value;

   // left of 1 means the high byte is next, anything else gives the low byte
   assign rd_byte  = (left_ff == 2'd1) ? latched_ff[15:8] : latched_ff[7:0];
   assign wr_value = ({cmd.wdata, pend_ff} == 16'd0) ? COUNT_MAX : {cmd.wdata, pend_ff};

   always_comb begin
      reload_in    = reload_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      high_next_in = high_next_ff;
      latched_in   = latched_ff;
      left_in      = left_ff;
      if (cmd.tick) begin
         if (reload_ff != 16'd0) begin
            phase_in = (phase_ff <= 16'd1) ? reload_ff : phase_ff - 16'd1;
         end
      end
      if (cmd.latch && left_ff == 2'd0) begin
         left_in = 2'd2;
         if (reload_ff <= 16'd1) begin
            reload_in  = divisor;
            phase_in   = divisor;
            latched_in = divisor;
         end else begin
            latched_in = phase_ff;
         end
      end
      if (cmd.clr_latch) begin
         left_in = 2'd0;
      end
      if (cmd.rd) begin
         left_in = (left_ff == 2'd0) ? 2'd1 : left_ff - 2'd1;
      end
      if (cmd.wr) begin
         if (!high_next_ff) begin
            pend_in      = cmd.wdata;
            high_next_in = 1'b1;
         end else begin
            reload_in    = wr_value;
            phase_in     = wr_value;
            high_next_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= '0;
         phase_ff     <= '0;
         pend_ff      <= '0;
         high_next_ff <= 1'b0;
         latched_ff   <= '0;
         left_ff      <= '0;
      end else begin
         reload_ff    <= reload_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         high_next_ff <= high_next_in;
         latched_ff   <= latched_in;
         left_ff      <= left_in;
      end
   end

endmodule

### rtl/core/interval_timer_three_channel.sv
// A response beat is registered in the output register, or in the skid entry
// while that is held. Throughput: one request beat per cycle while req_stall is
// low; the two-entry output buffer lets one more beat in after rsp_stall rises,
// then req_stall holds them off. Reset clears all channel state and the output
// buffer valid flags; the divisor register returns to 11932. No clearing pass is needed.
module interval_timer_three_channel #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_port,
   input  logic [2:0]  req_access_width,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_status
);
   import ivt_pkg::*;

   localparam logic [2:0] NUM_CH = 3'(NUM_CHANNELS);

   logic [15:0]  divisor_ff;
   logic [15:0]  divisor_eff;
   logic         accept;
   logic         pop;
   logic [1:0]   sel;
   logic [1:0]   rw;
   logic [3:0]   mode;
   logic         ctl_ok;
   logic         ctl_wr;
   logic         cnt_acc;
   logic         bad;
   chan_cmd_type cmd [NUM_CHANNELS];
   logic [7:0]   ch_byte [NUM_CHANNELS];
   rsp_type      result;
   logic [7:0]   rd_mux;
   rsp_type      out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   rsp_type      skid_ff, skid_in;
   logic         skid_valid_ff, skid_valid_in;

   assign accept      = req_valid && !req_stall;
   assign pop         = out_valid_ff && !rsp_stall;
   assign req_stall   = skid_valid_ff;
   assign divisor_eff = (divisor_ff == 16'd0) ? COUNT_MAX : divisor_ff;

   // control word decode
   assign sel    = req_write_data[7:6];
   assign rw     = req_write_data[5:4];
   assign mode   = req_write_data[3:0];
   assign ctl_ok = sel != SEL_READBACK
                && (rw == RW_LATCH
                    || (rw == RW_16BIT && (mode == MODE_RATEGEN || mode == MODE_SQWAVE)))
                && ({1'b0, sel} < NUM_CH);

   always_comb begin
      bad     = 1'b0;
      ctl_wr  = 1'b0;
      cnt_acc = 1'b0;
      if (req_kind == KIND_TICK) begin
         bad = 1'b0;
      end else if (req_kind != KIND_WRITE && req_kind != KIND_READ) begin
         bad = 1'b1;
      end else if (req_access_width != 3'd1) begin
         bad = 1'b1;
      end else if (req_port == CONTROL_PORT) begin
         if (req_kind == KIND_WRITE && ctl_ok) begin
            ctl_wr = 1'b1;
         end else begin
            bad = 1'b1;
         end
      end else if ({1'b0, req_port} >= NUM_CH) begin
         bad = 1'b1;
      end else begin
         cnt_acc = 1'b1;
      end
   end

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
      always_comb begin
         cmd[i].tick      = accept && req_kind == KIND_TICK;
         cmd[i].latch     = accept && ctl_wr && sel == 2'(i) && rw == RW_LATCH;
         cmd[i].clr_latch = accept && ctl_wr && sel == 2'(i) && rw == RW_16BIT;
         cmd[i].rd        = accept && cnt_acc && req_port == 2'(i) && req_kind == KIND_READ;
         cmd[i].wr        = accept && cnt_acc && req_port == 2'(i) && req_kind == KIND_WRITE;
         cmd[i].wdata     = req_write_data;
      end

      ivt_channel u_channel (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd[i]),
         .divisor (divisor_eff),
         .rd_byte (ch_byte[i])
      );
   end

   always_comb begin
      rd_mux = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (req_port == 2'(i)) begin
            rd_mux = ch_byte[i];
         end
      end
      result.status    = bad;
      result.read_data = (cnt_acc && req_kind == KIND_READ) ? rd_mux : 8'd0;
   end

   // output register plus skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff    <= DIVISOR_DEFAULT;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            divisor_ff <= csr_wr_data;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_status    = out_ff.status;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the three-channel interval timer.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ivt_pkg::*;

   localparam int CHANNELS = 3;
   localparam logic [2:0] ONE_BYTE = 3'd1;
   localparam logic [1:0] RW_LSB_ONLY = 2'd1;
   localparam logic [3:0] MODE_INTERRUPT = 4'h0;
   localparam logic [3:0] MODE_BCD_RATEGEN = 4'h5;

   // Mirrors the timer channels and holds the response beats still owed.
   class timer_scoreboard;
      logic [15:0] divisor;
      logic [15:0] reload [CHANNELS];
      logic [15:0] phase [CHANNELS];
      logic [15:0] latched [CHANNELS];
      logic [7:0]  low_byte [CHANNELS];
      bit          high_next [CHANNELS];
      logic [1:0]  bytes_left [CHANNELS];
      rsp_type     owed_q [$];
      int failures, reported;
      int n_ticks, n_reads, n_latches, n_programs, n_rejected, n_checked;

      function new();
         divisor = DIVISOR_DEFAULT;
         foreach (reload[i]) begin
            reload[i] = '0;
            phase[i] = '0;
            latched[i] = '0;
            low_byte[i] = '0;
            high_next[i] = 1'b0;
            bytes_left[i] = '0;
         end
      endfunction

      function void set_divisor(logic [15:0] v);
         divisor = v;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function logic control_word(logic [7:0] w);
         logic [1:0] sel;
         logic [1:0] rw;
         logic [3:0] mode;
         int ch;
         sel = w[7:6];
         rw = w[5:4];
         mode = w[3:0];
         ch = int'(sel);
         if (sel == SEL_READBACK) return 1'b1;
         if (rw != RW_LATCH && rw != RW_16BIT) return 1'b1;
         if (rw == RW_16BIT && mode != MODE_RATEGEN && mode != MODE_SQWAVE) return 1'b1;
         if (ch >= CHANNELS) return 1'b1;
         if (rw == RW_LATCH) begin
            n_latches++;
            if (bytes_left[ch] == 2'd0) begin
               // unprogrammed or reload of 1 falls back to the divisor
               if (reload[ch] <= 16'd1) begin
                  reload[ch] = (divisor == 16'd0) ? COUNT_MAX : divisor;
                  phase[ch] = reload[ch];
               end
               latched[ch] = phase[ch];
               bytes_left[ch] = 2'd2;
            end
         end else begin
            n_programs++;
            bytes_left[ch] = 2'd0;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [1:0] kind, logic [1:0] port, logic [2:0] width,
                                 logic [7:0] data);
         rsp_type want;
         logic [15:0] r;
         int ch;
         want = '0;
         ch = int'(port);
         if (kind == KIND_TICK) begin
            n_ticks++;
            foreach (reload[i]) begin
               if (reload[i] != 16'd0)
                  phase[i] = (phase[i] <= 16'd1) ? reload[i] : phase[i] - 16'd1;
            end
         end else if ((kind != KIND_WRITE && kind != KIND_READ) || width != ONE_BYTE) begin
            want.status = 1'b1;
         end else if (port == CONTROL_PORT) begin
            want.status = (kind == KIND_WRITE) ? control_word(data) : 1'b1;
         end else if (ch >= CHANNELS) begin
            want.status = 1'b1;
         end else if (kind == KIND_READ) begin
            n_reads++;
            if (bytes_left[ch] == 2'd0) bytes_left[ch] = 2'd2;
            bytes_left[ch] = bytes_left[ch] - 2'd1;
            want.read_data = (bytes_left[ch] == 2'd1) ? latched[ch][7:0] : latched[ch][15:8];
         end else if (!high_next[ch]) begin
            low_byte[ch] = data;
            high_next[ch] = 1'b1;
         end else begin
            r = {data, low_byte[ch]};
            if (r == 16'd0) r = COUNT_MAX;
            reload[ch] = r;
            phase[ch] = r;
            high_next[ch] = 1'b0;
         end
         if (want.status) n_rejected++;
         owed_q.push_back(want);
      endfunction

      function void check_response(logic [7:0] rd, logic st);
         rsp_type want;
         if (owed_q.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: response beat with none owed: read_data %02h status %0d", rd, st);
            end
            return;
         end
         want = owed_q.pop_front();
         n_checked++;
         if (rd !== want.read_data || st !== want.status) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: response %0d: read_data exp %02h got %02h, status exp %0d got %0d",
                        n_checked, want.read_data, rd, want.status, st);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [1:0]  req_port;
   logic [2:0]  req_access_width;
   logic [7:0]  req_write_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_read_data;
   logic        rsp_status;

   timer_scoreboard sb;
   bit tx_idle;
   bit rx_idle;
   int hold_requests;
   int holds_done;
   int hold_left;
   int rx_burst;

   interval_timer_three_channel #(.NUM_CHANNELS(CHANNELS)) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_port(req_port),
      .req_access_width(req_access_width),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("interval_timer_three_channel: mismatch");
      $finish;
   end

   // Monitor: responses are checked before the request beat of the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_read_data, rsp_status);
         if (req_valid && !req_stall)
            sb.note_request(req_kind, req_port, req_access_width, req_write_data);
         if (csr_wr_en) sb.set_divisor(csr_wr_data);
      end
   end

   // Receiver: random stall bursts while rx_idle is set, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = 80;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0) rsp_stall <= 1'b0;
      end else if (!rx_idle) begin
         rsp_stall <= 1'b0;
      end else if (rx_burst > 0) begin
         rx_burst--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         rx_burst = $urandom_range(1, 9) - 1;
      end else begin
         rsp_stall <= 1'b0;
         rx_burst = $urandom_range(1, 20) - 1;
      end
   end

   task automatic send(input logic [1:0] kind, input logic [1:0] port,
                       input logic [2:0] width, input logic [7:0] data);
      if (tx_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_port <= port;
      req_access_width <= width;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
   endtask

   // Divisor writes only once every owed response beat is in.
   task automatic write_divisor(input logic [15:0] v);
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Reload bytes lean toward zero and small values so counts wrap often.
   function automatic logic [7:0] count_byte();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return 8'd0;
         default: return 8'($urandom_range(0, 12));
      endcase
   endfunction

   task automatic random_traffic(input int n);
      int done_n;
      int r;
      int reps;
      logic [1:0] ch;
      done_n = 0;
      while (done_n < n) begin
         r = $urandom_range(0, 99);
         ch = 2'($urandom_range(0, CHANNELS - 1));
         if (r < 28) begin
            send(KIND_TICK, 2'($urandom), 3'($urandom), 8'($urandom));
            done_n += 1;
         end else if (r < 40) begin
            reps = $urandom_range(2, 12);
            repeat (reps) send(KIND_TICK, 2'($urandom), 3'($urandom), 8'($urandom));
            done_n += reps;
         end else if (r < 54) begin
            send(KIND_WRITE, CONTROL_PORT, ONE_BYTE,
                 {ch, RW_16BIT, ($urandom_range(0, 1) ? MODE_RATEGEN : MODE_SQWAVE)});
            send(KIND_WRITE, ch, ONE_BYTE, count_byte());
            send(KIND_WRITE, ch, ONE_BYTE, count_byte());
            done_n += 3;
         end else if (r < 69) begin
            send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {ch, RW_LATCH, 4'($urandom)});
            send(KIND_READ, ch, ONE_BYTE, 8'($urandom));
            send(KIND_READ, ch, ONE_BYTE, 8'($urandom));
            done_n += 3;
         end else if (r < 77) begin
            send(KIND_READ, ch, ONE_BYTE, 8'($urandom));
            done_n += 1;
         end else if (r < 85) begin
            send(KIND_WRITE, ch, ONE_BYTE, count_byte());
            done_n += 1;
         end else if (r < 92) begin
            send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, 8'($urandom));
            done_n += 1;
         end else begin
            send(2'($urandom), 2'($urandom), 3'($urandom), 8'($urandom));
            done_n += 1;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_TICK;
      req_port <= '0;
      req_access_width <= ONE_BYTE;
      req_write_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      rsp_stall <= 1'b0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      hold_requests = 0;
      holds_done = 0;
      hold_left = 0;
      rx_burst = 0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // nothing latched yet, then latch of an unprogrammed channel
      send(KIND_READ, 2'd0, ONE_BYTE, 8'h00);
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd0, RW_LATCH, 4'hf});
      send(KIND_READ, 2'd0, ONE_BYTE, 8'h00);
      send(KIND_READ, 2'd0, ONE_BYTE, 8'h00);
      send(KIND_TICK, 2'd3, 3'd7, 8'hff);
      // zero reload becomes full scale; second latch is ignored
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd1, RW_16BIT, MODE_RATEGEN});
      send(KIND_WRITE, 2'd1, ONE_BYTE, 8'h00);
      send(KIND_WRITE, 2'd1, ONE_BYTE, 8'h00);
      send(KIND_TICK, 2'd0, 3'd0, 8'h00);
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd1, RW_LATCH, MODE_INTERRUPT});
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd1, RW_LATCH, MODE_INTERRUPT});
      send(KIND_READ, 2'd1, ONE_BYTE, 8'h00);
      send(KIND_READ, 2'd1, ONE_BYTE, 8'h00);
      // program word between low and high byte keeps the byte order
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd2, RW_16BIT, MODE_SQWAVE});
      send(KIND_WRITE, 2'd2, ONE_BYTE, 8'h01);
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd2, RW_16BIT, MODE_RATEGEN});
      send(KIND_WRITE, 2'd2, ONE_BYTE, 8'h00);
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd2, RW_LATCH, MODE_INTERRUPT});
      send(KIND_READ, 2'd2, ONE_BYTE, 8'h00);
      send(KIND_READ, 2'd2, ONE_BYTE, 8'h00);
      // rejected accesses
      send(KIND_WRITE, 2'd0, 3'd0, 8'h12);
      send(KIND_READ, 2'd1, 3'd4, 8'h00);
      send(2'd3, 2'd0, ONE_BYTE, 8'h00);
      send(KIND_READ, CONTROL_PORT, ONE_BYTE, 8'h00);
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, 8'hff);
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd0, RW_LSB_ONLY, MODE_RATEGEN});
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd0, RW_16BIT, MODE_BCD_RATEGEN});
      send(KIND_WRITE, CONTROL_PORT, ONE_BYTE, {2'd0, RW_16BIT, MODE_INTERRUPT});

      write_divisor(16'd1);
      random_traffic(110);
      // long receiver hold while requests keep coming
      write_divisor(COUNT_MAX);
      hold_requests++;
      tx_idle = 1'b0;
      random_traffic(30);
      tx_idle = 1'b1;
      random_traffic(90);
      write_divisor(16'd0);
      random_traffic(100);
      write_divisor(16'($urandom_range(2, 40)));
      random_traffic(140);
      write_divisor(16'($urandom_range(1, 65535)));
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      random_traffic(130);

      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (5) @(posedge clock);
      $display("run covered %0d ticks, %0d counter reads, %0d latches, %0d program words",
               sb.n_ticks, sb.n_reads, sb.n_latches, sb.n_programs);
      $display("%0d rejected accesses, %0d response beats checked, %0d failures",
               sb.n_rejected, sb.n_checked, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("interval_timer_three_channel: match");
      else
         $display("interval_timer_three_channel: mismatch");
      $finish;
   end

endmodule
